// File: hw/rtl/arc_pkg.sv
// arc_pkg: shared types, constants and codes of the ARP receive cache/reply unit.
// Used by arc_cache_mem, arc_ctrl and arp_receive_cache_reply_unit; no dependencies.
`timescale 1ns / 1ps

package arc_pkg;

	localparam int CACHE_ENTRIES = 32;
	localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(CACHE_ENTRIES + 1);

	localparam logic [15:0] HW_ETHERNET = 16'h0001;
	localparam logic [15:0] PROTO_IPV4  = 16'h0800;
	localparam logic [15:0] OP_REQUEST  = 16'h0001;
	localparam logic [15:0] OP_REPLY    = 16'h0002;

	// Configuration register indexes
	localparam logic REG_OWN_IP  = 1'b0;
	localparam logic REG_OWN_MAC = 1'b1;

	typedef enum logic [2:0] {
		ST_BAD_HW    = 3'd0,
		ST_BAD_PROTO = 3'd1,
		ST_UPDATED   = 3'd2,
		ST_INSERTED  = 3'd3,
		ST_FULL      = 3'd4,
		ST_NOT_US    = 3'd5
	} arc_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} arc_state_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_addr;
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		logic [31:0]      wr_ip;
		logic [47:0]      wr_mac;
	} arc_mem_req_t;

	typedef struct packed {
		arc_status_t status;
		logic        send_reply;
		logic [15:0] reply_opcode;
		logic [47:0] reply_sender_mac;
		logic [31:0] reply_sender_ip;
		logic [47:0] reply_target_mac;
		logic [31:0] reply_target_ip;
	} arc_result_t;

endpackage

// File: hw/rtl/arc_cache_mem.sv
// arc_cache_mem: cache entry store (IP and MAC per entry), one write and one read port.
// Read data is registered. Depends on arc_pkg.
`timescale 1ns / 1ps

module arc_cache_mem (
	input  logic                 clk,
	input  arc_pkg::arc_mem_req_t req,
	output logic [31:0]          rd_ip
);

	logic [31:0] ip_mem [arc_pkg::CACHE_ENTRIES];
	logic [47:0] mac_mem [arc_pkg::CACHE_ENTRIES];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			ip_mem[req.wr_addr]  <= req.wr_ip;
			mac_mem[req.wr_addr] <= req.wr_mac;
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd_en) begin
			rd_ip <= ip_mem[req.rd_addr];
		end
	end

endmodule

// File: hw/rtl/arc_ctrl.sv
// arc_ctrl: packet sequencer, entry valid bits and result register.
// Walks the cache memory one entry a cycle. Depends on arc_pkg.
`timescale 1ns / 1ps

module arc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [15:0]           hardware_type,
	input  logic [15:0]           protocol_type,
	input  logic [15:0]           operation,
	input  logic [47:0]           sender_mac,
	input  logic [31:0]           sender_ip,
	input  logic [31:0]           target_ip,
	input  logic [31:0]           own_ip,
	input  logic [47:0]           own_mac,
	input  logic [31:0]           rd_ip,
	output logic                  busy,
	output arc_pkg::arc_mem_req_t mem_req,
	output arc_pkg::arc_result_t  res,
	output logic                  done
);

	localparam logic [arc_pkg::CNT_W-1:0] LAST_CNT = arc_pkg::CNT_W'(arc_pkg::CACHE_ENTRIES);

	arc_pkg::arc_state_t state_q, state_d;

	logic [arc_pkg::CACHE_ENTRIES-1:0] valid_q;
	logic [arc_pkg::CNT_W-1:0]         idx_q;
	logic                              cmp_s1;
	logic [arc_pkg::IDX_W-1:0]         cmp_idx_s1;
	logic                              hit_q;
	logic [arc_pkg::IDX_W-1:0]         hit_idx_q;
	logic                              free_found_q;
	logic [arc_pkg::IDX_W-1:0]         free_idx_q;
	logic [15:0]                       op_q;
	logic [47:0]                       smac_q;
	logic [31:0]                       sip_q;
	logic [31:0]                       tip_q;

	logic                 drop;
	arc_pkg::arc_status_t drop_status;
	logic                 last;
	logic                 hit_now;
	logic                 free_now;
	logic                 for_us;
	logic                 do_insert;
	arc_pkg::arc_result_t fin_res;

	assign drop        = (hardware_type != arc_pkg::HW_ETHERNET) ||
	                     (protocol_type != arc_pkg::PROTO_IPV4);
	assign drop_status = (hardware_type != arc_pkg::HW_ETHERNET) ?
	                     arc_pkg::ST_BAD_HW : arc_pkg::ST_BAD_PROTO;
	assign last        = (idx_q == LAST_CNT);
	assign hit_now     = cmp_s1 && valid_q[cmp_idx_s1] && (rd_ip == sip_q);
	assign free_now    = cmp_s1 && !valid_q[cmp_idx_s1] && !free_found_q;
	assign for_us      = (tip_q == own_ip);
	assign busy        = (state_q != arc_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= arc_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d         = state_q;
		mem_req.rd_en   = 1'b0;
		mem_req.rd_addr = idx_q[arc_pkg::IDX_W-1:0];
		mem_req.wr_en   = 1'b0;
		mem_req.wr_addr = hit_idx_q;
		mem_req.wr_ip   = sip_q;
		mem_req.wr_mac  = smac_q;
		do_insert       = 1'b0;
		fin_res         = '0;
		case (state_q)
			arc_pkg::S_IDLE: begin
				if (drop) begin
					fin_res.status = drop_status;
				end
				if (start && !drop) begin
					state_d = arc_pkg::S_SCAN;
				end
			end
			arc_pkg::S_SCAN: begin
				mem_req.rd_en = !last;
				if (hit_now || last) begin
					state_d = arc_pkg::S_FINISH;
				end
			end
			arc_pkg::S_FINISH: begin
				state_d = arc_pkg::S_IDLE;
				if (hit_q) begin
					fin_res.status = arc_pkg::ST_UPDATED;
					mem_req.wr_en  = 1'b1;
				end else if (!for_us) begin
					fin_res.status = arc_pkg::ST_NOT_US;
				end else if (free_found_q) begin
					fin_res.status  = arc_pkg::ST_INSERTED;
					mem_req.wr_en   = 1'b1;
					mem_req.wr_addr = free_idx_q;
					do_insert       = 1'b1;
				end else begin
					fin_res.status = arc_pkg::ST_FULL;
				end
				if (for_us && (op_q == arc_pkg::OP_REQUEST)) begin
					fin_res.send_reply       = 1'b1;
					fin_res.reply_opcode     = arc_pkg::OP_REPLY;
					fin_res.reply_sender_mac = own_mac;
					fin_res.reply_sender_ip  = own_ip;
					fin_res.reply_target_mac = smac_q;
					fin_res.reply_target_ip  = sip_q;
				end
			end
			default: begin
				state_d = arc_pkg::S_IDLE;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= '0;
			idx_q        <= '0;
			cmp_s1       <= 1'b0;
			hit_q        <= 1'b0;
			free_found_q <= 1'b0;
			done         <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				arc_pkg::S_IDLE: begin
					if (start) begin
						idx_q        <= '0;
						cmp_s1       <= 1'b0;
						hit_q        <= 1'b0;
						free_found_q <= 1'b0;
						done         <= drop;
					end
				end
				arc_pkg::S_SCAN: begin
					cmp_s1 <= !last;
					if (!last) begin
						idx_q <= idx_q + arc_pkg::CNT_W'(1);
					end
					if (hit_now) begin
						hit_q <= 1'b1;
					end
					if (free_now) begin
						free_found_q <= 1'b1;
					end
				end
				arc_pkg::S_FINISH: begin
					done <= 1'b1;
					if (do_insert) begin
						valid_q[free_idx_q] <= 1'b1;
					end
				end
				default: begin
					cmp_s1 <= 1'b0;
				end
			endcase
		end
	end

	// payload: packet fields, entry indexes, result
	always_ff @(posedge clk) begin
		case (state_q)
			arc_pkg::S_IDLE: begin
				if (start) begin
					op_q   <= operation;
					smac_q <= sender_mac;
					sip_q  <= sender_ip;
					tip_q  <= target_ip;
					if (drop) begin
						res <= fin_res;
					end
				end
			end
			arc_pkg::S_SCAN: begin
				cmp_idx_s1 <= idx_q[arc_pkg::IDX_W-1:0];
				if (hit_now) begin
					hit_idx_q <= cmp_idx_s1;
				end
				if (free_now) begin
					free_idx_q <= cmp_idx_s1;
				end
			end
			arc_pkg::S_FINISH: begin
				res <= fin_res;
			end
			default: begin
				res <= res;
			end
		endcase
	end

endmodule

// File: hw/rtl/arp_receive_cache_reply_unit.sv
// arp_receive_cache_reply_unit: top level, configuration registers and ports.
// Depends on arc_pkg, arc_ctrl and arc_cache_mem.
// Timing: a dropped packet (bad hardware or protocol type) shows its result in the cycle after
//   the start transfer; otherwise the unit walks the cache entries until a sender hit or the
//   last entry, then finishes and shows the result at the result transfer.
// Throughput: one packet at a time; start is taken again once busy falls (also while done shows).
// Reset: arst_n clears the state machine, all entry valid bits, own_ip and own_mac at once.
// done is high for exactly one cycle per packet; the receiver cannot stall it.
`timescale 1ns / 1ps

module arp_receive_cache_reply_unit (
	input  logic        clk,
	input  logic        arst_n,
	// packet transfer
	input  logic        start,
	output logic        busy,
	input  logic [15:0] hardware_type,
	input  logic [15:0] protocol_type,
	input  logic [15:0] operation,
	input  logic [47:0] sender_mac,
	input  logic [31:0] sender_ip,
	input  logic [31:0] target_ip,
	// configuration write port
	input  logic        wr_en,
	input  logic        wr_index,
	input  logic [47:0] wr_data,
	// result transfer, one cycle per packet
	output logic        done,
	output logic [2:0]  status,
	output logic        send_reply,
	output logic [15:0] reply_opcode,
	output logic [47:0] reply_sender_mac,
	output logic [31:0] reply_sender_ip,
	output logic [47:0] reply_target_mac,
	output logic [31:0] reply_target_ip
);

	logic [31:0] own_ip_q;
	logic [47:0] own_mac_q;

	arc_pkg::arc_mem_req_t mem_req;
	arc_pkg::arc_result_t  res;
	logic [31:0]           rd_ip;

	// Hold our addresses; the user must write them only while the unit is idle (not enforced here).
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_ip_q  <= '0;
			own_mac_q <= '0;
		end else if (wr_en) begin
			case (wr_index)
				arc_pkg::REG_OWN_IP:  own_ip_q  <= wr_data[31:0];
				arc_pkg::REG_OWN_MAC: own_mac_q <= wr_data;
				default:              own_ip_q  <= own_ip_q;
			endcase
		end
	end

	// Sequencer: latch the packet, walk the cache, update or insert, build the reply.
	arc_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.hardware_type (hardware_type),
		.protocol_type (protocol_type),
		.operation     (operation),
		.sender_mac    (sender_mac),
		.sender_ip     (sender_ip),
		.target_ip     (target_ip),
		.own_ip        (own_ip_q),
		.own_mac       (own_mac_q),
		.rd_ip         (rd_ip),
		.busy          (busy),
		.mem_req       (mem_req),
		.res           (res),
		.done          (done)
	);

	// Entry store: IP and MAC of every cache entry.
	arc_cache_mem u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rd_ip (rd_ip)
	);

	assign status           = res.status;
	assign send_reply       = res.send_reply;
	assign reply_opcode     = res.reply_opcode;
	assign reply_sender_mac = res.reply_sender_mac;
	assign reply_sender_ip  = res.reply_sender_ip;
	assign reply_target_mac = res.reply_target_mac;
	assign reply_target_ip  = res.reply_target_ip;

endmodule

// File: sim/tb_arp_receive_cache_reply_unit.sv
// tb_arp_receive_cache_reply_unit: self-checking testbench for the ARP receive cache/reply unit.
// Depends on arc_pkg and arp_receive_cache_reply_unit; drives packets, predicts every result.
`timescale 1ns / 1ps

module tb_arp_receive_cache_reply_unit;

	import arc_pkg::*;

	// Settle time after the last result: one full cache walk plus margin.
	localparam int QUIET_CYCLES = CACHE_ENTRIES + 8;
	// Sender IP pool; larger than the cache so the table fills and stays full.
	localparam int POOL_N = CACHE_ENTRIES + 8;

	typedef struct {
		logic [15:0] hw;
		logic [15:0] proto;
		logic [15:0] op;
		logic [47:0] smac;
		logic [31:0] sip;
		logic [31:0] tip;
	} arp_pkt_t;

	// Block inputs, all known from time zero.
	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        start         = 1'b0;
	logic [15:0] hardware_type = '0;
	logic [15:0] protocol_type = '0;
	logic [15:0] operation     = '0;
	logic [47:0] sender_mac    = '0;
	logic [31:0] sender_ip     = '0;
	logic [31:0] target_ip     = '0;
	logic        wr_en         = 1'b0;
	logic        wr_index      = REG_OWN_IP;
	logic [47:0] wr_data       = '0;

	// Block outputs.
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic        send_reply;
	logic [15:0] reply_opcode;
	logic [47:0] reply_sender_mac;
	logic [31:0] reply_sender_ip;
	logic [47:0] reply_target_mac;
	logic [31:0] reply_target_ip;

	// Shadow of the block: own addresses and the translation cache.
	logic [31:0] cfg_own_ip                   = '0;
	logic [47:0] cfg_own_mac                  = '0;
	logic        cache_valid [CACHE_ENTRIES]  = '{default: 1'b0};
	logic [31:0] cache_ip    [CACHE_ENTRIES];
	logic [47:0] cache_mac   [CACHE_ENTRIES];

	arp_pkt_t    rx_pkt_q[$];    // packets waiting to be offered
	arc_result_t outcome_q[$];   // predicted results, oldest first
	arp_pkt_t    held_pkt;       // packet currently on the input ports
	logic [31:0] ip_pool [POOL_N];
	int          queued_cnt   = 0;
	int          accepted_cnt = 0;
	int          err_cnt      = 0;
	int          idle_pct     = 0;

	arp_receive_cache_reply_unit u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.hardware_type    (hardware_type),
		.protocol_type    (protocol_type),
		.operation        (operation),
		.sender_mac       (sender_mac),
		.sender_ip        (sender_ip),
		.target_ip        (target_ip),
		.wr_en            (wr_en),
		.wr_index         (wr_index),
		.wr_data          (wr_data),
		.done             (done),
		.status           (status),
		.send_reply       (send_reply),
		.reply_opcode     (reply_opcode),
		.reply_sender_mac (reply_sender_mac),
		.reply_sender_ip  (reply_sender_ip),
		.reply_target_mac (reply_target_mac),
		.reply_target_ip  (reply_target_ip)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Work out the result of one packet and apply its effect on the shadow cache.
	// Update wins over insert: a known sender is refreshed even when the packet is
	// not for us. Only packets aimed at our IP may claim a free entry.
	function automatic arc_result_t compute_arp_outcome(arp_pkt_t p);
		arc_result_t r;
		logic        hit;
		logic        placed;
		logic        for_us;
		r      = '0;
		hit    = 1'b0;
		placed = 1'b0;
		if (p.hw != HW_ETHERNET) begin
			r.status = ST_BAD_HW;
			return r;
		end
		if (p.proto != PROTO_IPV4) begin
			r.status = ST_BAD_PROTO;
			return r;
		end
		for_us = (p.tip == cfg_own_ip);
		for (int i = 0; i < CACHE_ENTRIES; i++) begin
			if (!hit && cache_valid[i] && cache_ip[i] == p.sip) begin
				cache_mac[i] = p.smac;
				hit          = 1'b1;
			end
		end
		if (hit) begin
			r.status = ST_UPDATED;
		end else if (!for_us) begin
			r.status = ST_NOT_US;
		end else begin
			for (int i = 0; i < CACHE_ENTRIES; i++) begin
				if (!placed && !cache_valid[i]) begin
					cache_valid[i] = 1'b1;
					cache_ip[i]    = p.sip;
					cache_mac[i]   = p.smac;
					placed         = 1'b1;
				end
			end
			r.status = placed ? ST_INSERTED : ST_FULL;
		end
		// A full table still answers a request aimed at us.
		if (for_us && p.op == OP_REQUEST) begin
			r.send_reply       = 1'b1;
			r.reply_opcode     = OP_REPLY;
			r.reply_sender_mac = cfg_own_mac;
			r.reply_sender_ip  = cfg_own_ip;
			r.reply_target_mac = p.smac;
			r.reply_target_ip  = p.sip;
		end
		return r;
	endfunction

	function automatic logic [47:0] rand48();
		return {16'($urandom), 32'($urandom)};
	endfunction

	function automatic arp_pkt_t mk_pkt(logic [15:0] hw, logic [15:0] proto, logic [15:0] op,
			logic [47:0] smac, logic [31:0] sip, logic [31:0] tip);
		arp_pkt_t p;
		p.hw    = hw;
		p.proto = proto;
		p.op    = op;
		p.smac  = smac;
		p.sip   = sip;
		p.tip   = tip;
		return p;
	endfunction

	// Mostly well-formed Ethernet/IPv4 packets with senders drawn from the pool, so
	// updates, inserts and the full table all show up; the rest is header noise.
	function automatic arp_pkt_t gen_arp_pkt();
		arp_pkt_t p;
		int       roll;
		p = mk_pkt(16'($urandom), 16'($urandom), 16'($urandom), rand48(), $urandom, $urandom);
		if ($urandom_range(99) < 80) begin
			p.hw    = HW_ETHERNET;
			p.proto = PROTO_IPV4;
			roll    = $urandom_range(99);
			if (roll < 60)
				p.op = OP_REQUEST;
			else if (roll < 85)
				p.op = OP_REPLY;
			if ($urandom_range(99) < 75)
				p.sip = ip_pool[$urandom_range(POOL_N - 1)];
			roll = $urandom_range(99);
			if (roll < 55)
				p.tip = cfg_own_ip;
			else if (roll < 70)
				p.tip = ip_pool[$urandom_range(POOL_N - 1)];
		end else if ($urandom_range(1) == 1) begin
			// good hardware type, junk protocol
			p.hw = HW_ETHERNET;
		end
		return p;
	endfunction

	task automatic queue_pkt(arp_pkt_t p);
		rx_pkt_q.push_back(p);
		queued_cnt++;
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++)
			queue_pkt(gen_arp_pkt());
	endtask

	// Write both address registers on back-to-back edges; call only while idle.
	// Pad the IP write with junk above bit 31 so the block must drop it.
	task automatic set_own_addr(logic [31:0] ip, logic [47:0] mac);
		wr_en    <= 1'b1;
		wr_index <= REG_OWN_IP;
		wr_data  <= {16'($urandom), ip};
		@(posedge clk);
		wr_index <= REG_OWN_MAC;
		wr_data  <= mac;
		@(posedge clk);
		wr_en       <= 1'b0;
		cfg_own_ip  = ip;
		cfg_own_mac = mac;
	endtask

	// Hold until every queued packet is taken and every result has come, then settle.
	task automatic wait_quiet();
		while (accepted_cnt != queued_cnt)
			@(posedge clk);
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (QUIET_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(string name, logic [47:0] want, logic [47:0] got);
		if (want !== got) begin
			err_cnt++;
			$error("%s: expected %0h, got %0h", name, want, got);
		end
	endtask

	// Sender. A transfer happens at an edge with start high and busy low: predict it
	// there. Offer the next packet whenever the port is free, unless this cycle idles;
	// a packet offered while busy is held until the block takes it.
	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				outcome_q.push_back(compute_arp_outcome(held_pkt));
				accepted_cnt++;
			end
			if (!start || !busy) begin
				if (rx_pkt_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
					held_pkt = rx_pkt_q.pop_front();
					start         <= 1'b1;
					hardware_type <= held_pkt.hw;
					protocol_type <= held_pkt.proto;
					operation     <= held_pkt.op;
					sender_mac    <= held_pkt.smac;
					sender_ip     <= held_pkt.sip;
					target_ip     <= held_pkt.tip;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Receiver. done lasts one cycle and cannot be held off: check it at the edge
	// that ends that cycle against the oldest prediction.
	always @(posedge clk) begin
		arc_result_t want;
		if (arst_n && done === 1'b1) begin
			if (outcome_q.size() == 0) begin
				err_cnt++;
				$error("result transfer with no packet outstanding");
			end else begin
				want = outcome_q.pop_front();
				check_field("status", 48'(want.status), 48'(status));
				check_field("send_reply", 48'(want.send_reply), 48'(send_reply));
				check_field("reply_opcode", 48'(want.reply_opcode), 48'(reply_opcode));
				check_field("reply_sender_mac", want.reply_sender_mac, reply_sender_mac);
				check_field("reply_sender_ip", 48'(want.reply_sender_ip),
					48'(reply_sender_ip));
				check_field("reply_target_mac", want.reply_target_mac, reply_target_mac);
				check_field("reply_target_ip", 48'(want.reply_target_ip),
					48'(reply_target_ip));
			end
		end
	end

	initial begin
		logic [31:0] me;
		for (int i = 0; i < POOL_N; i++)
			ip_pool[i] = $urandom;
		ip_pool[0] = '0;
		ip_pool[1] = '1;

		// Hold reset low, then release it at a rising edge.
		@(negedge clk);
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: header extremes, every opcode class, update/insert/not-us paths.
		idle_pct = 10;
		me = 32'hC0A8_0101;
		set_own_addr(me, 48'h0200_5E00_0001);
		queue_pkt(mk_pkt(16'h0000, PROTO_IPV4, OP_REQUEST, rand48(), $urandom, me));
		queue_pkt(mk_pkt(16'hFFFF, 16'hFFFF, OP_REQUEST, rand48(), $urandom, me));
		queue_pkt(mk_pkt(HW_ETHERNET, 16'h0000, OP_REQUEST, rand48(), $urandom, me));
		queue_pkt(mk_pkt(HW_ETHERNET, 16'hFFFF, OP_REPLY, rand48(), $urandom, me));
		queue_pkt(mk_pkt(16'h0800, 16'h0001, OP_REQUEST, rand48(), $urandom, me));
		queue_pkt(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'h0, 32'h0, me));
		queue_pkt(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, '1, '1, me));
		queue_pkt(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REPLY, rand48(), 32'h0A00_0001, me));
		queue_pkt(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand48(), 32'h0A00_0002,
			me ^ 32'h1));
		// known sender, not for us: refresh the entry but stay silent
		queue_pkt(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand48(), 32'h0, 32'h0));
		queue_pkt(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand48(), 32'h0, me));
		queue_pkt(mk_pkt(HW_ETHERNET, PROTO_IPV4, 16'h0000, rand48(), 32'h0A00_0003, me));
		queue_pkt(mk_pkt(HW_ETHERNET, PROTO_IPV4, 16'hFFFF, rand48(), 32'h0A00_0004, me));
		queue_pkt(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REPLY, rand48(), '1, '1));
		queue_pkt(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand48(), 32'h0A00_0005, '1));
		queue_pkt(mk_pkt(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, rand48(), 32'h0A00_0001, me));
		wait_quiet();

		// Random phases; each boundary drains the block before the registers move.
		set_own_addr('1, '1);
		queue_random(400);
		wait_quiet();

		idle_pct = 85;
		set_own_addr('0, '0);
		queue_random(400);
		wait_quiet();

		idle_pct = 0;
		set_own_addr($urandom, rand48());
		queue_random(334);
		wait_quiet();

		if (err_cnt == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
